>>> rtl/dilv_pkg.sv
// shared types and constants of the decimal list validator
`default_nettype none

package dilv_pkg;

	// value table depth and derived widths
	localparam int MAX_ITEMS = 512;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int COUNT_W   = 10;
	localparam int VALUE_W   = 32;
	localparam int MAG_W     = 35;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	// 2^31, largest magnitude still tracked
	localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(64'h8000_0000);

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_END_TOKEN = 2'd1,
		KIND_END_LIST  = 2'd2,
		KIND_CLEAR     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_MALFORMED = 3'd1,
		STAT_RANGE     = 3'd2,
		STAT_DUP       = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_EMPTY     = 3'd5,
		STAT_HALTED    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		OP_TOKEN = 2'd0,
		OP_LIST  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		status_t            pre;      // status known from the token alone
		logic [VALUE_W-1:0] value;    // signed token value
		logic               started;  // a token was open at end of list
	} q_entry_t;

endpackage

`default_nettype wire

>>> rtl/dilv_front.sv
// front end: character parser and command classifier
`default_nettype none

module dilv_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          kind,
	input  wire logic [7:0]          ch,
	output logic                     q_push,
	output dilv_pkg::q_entry_t       q_entry,
	input  wire logic                q_full
);
	import dilv_pkg::*;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic               first_q;
	logic               bad_q;
	logic               big_q;

	logic               accept;
	logic               is_digit;
	logic               is_sign;
	logic [MAG_W-1:0]   mag_ext;
	logic [MAG_W-1:0]   mag_next;
	logic               over;
	status_t            pre_st;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;

	always_comb begin
		is_digit = ch inside {[CH_ZERO:CH_NINE]};
		is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
	end

	// magnitude * 10 + digit
	assign mag_ext  = MAG_W'(mag_q);
	assign mag_next = (mag_ext << 3) + (mag_ext << 1) + MAG_W'(ch - CH_ZERO);
	assign over     = mag_next > MAG_LIMIT;

	always_comb begin
		if (bad_q) begin
			pre_st = STAT_MALFORMED;
		end else if (big_q || (!neg_q && mag_q[VALUE_W-1])) begin
			pre_st = STAT_RANGE;
		end else begin
			pre_st = STAT_OK;
		end
	end

	always_comb begin
		q_entry.pre     = pre_st;
		q_entry.value   = neg_q ? (VALUE_W'(0) - mag_q) : mag_q;
		q_entry.started = ~first_q;
		case (kind)
			KIND_END_TOKEN: q_entry.op = OP_TOKEN;
			KIND_END_LIST:  q_entry.op = OP_LIST;
			default:        q_entry.op = OP_CLEAR;
		endcase
	end

	assign q_push = accept && (kind != KIND_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			bad_q   <= 1'b0;
			big_q   <= 1'b0;
		end else if (accept) begin
			if (kind == KIND_CHAR) begin
				if (first_q && is_sign) begin
					neg_q <= (ch == CH_MINUS);
				end else if (is_digit) begin
					if (!big_q) begin
						if (over) begin
							big_q <= 1'b1;
						end else begin
							mag_q <= mag_next[VALUE_W-1:0];
						end
					end
				end else begin
					bad_q <= 1'b1;
				end
				first_q <= 1'b0;
			end else begin
				mag_q   <= '0;
				neg_q   <= 1'b0;
				first_q <= 1'b1;
				bad_q   <= 1'b0;
				big_q   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/dilv_queue.sv
// small command fifo between front and back
`default_nettype none

module dilv_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire dilv_pkg::q_entry_t  push_entry,
	output logic                     full,
	input  wire logic                pop,
	output logic                     pop_valid,
	output dilv_pkg::q_entry_t       pop_entry
);
	import dilv_pkg::*;

	q_entry_t          slot_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     fill_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (fill_q == (Q_AW+1)'(Q_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (Q_AW+1)'(1);
				2'b01:   fill_q <= fill_q - (Q_AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue fill beyond depth");
`endif

endmodule

`default_nettype wire

>>> rtl/dilv_back.sv
// back end: duplicate scan, value table and result register
`default_nettype none

module dilv_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire dilv_pkg::q_entry_t  q_entry,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               status,
	output logic [31:0]              value,
	output logic [9:0]               count,
	output logic                     list_end
);
	import dilv_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_inc;
	logic                halted_q;
	logic [CNT_W-1:0]    idx_q;
	logic                pend_s1;
	logic [VALUE_W-1:0]  rdata_s1;
	logic [VALUE_W-1:0]  cur_q;
	status_t             res_st_q;
	status_t             list_st;

	logic                out_valid_q;
	status_t             status_q;
	logic [VALUE_W-1:0]  value_q;
	logic [COUNT_W-1:0]  count_q;
	logic                list_end_q;

	logic [VALUE_W-1:0]  table_mem [MAX_ITEMS];

	logic                out_free;
	logic                out_load;
	logic                match;
	logic                scan_end;
	logic                mem_re;
	logic                mem_we;

	assign out_free = ~out_valid_q | out_ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign match    = pend_s1 && (rdata_s1 == cur_q);
	assign scan_end = (idx_q == cnt_q) && !pend_s1;
	assign mem_re   = (state_q == S_SCAN) && (idx_q != cnt_q) && !match;
	assign mem_we   = (state_q == S_DONE) && out_free && (res_st_q == STAT_OK);

	// a result beat is loaded on an immediate answer or at the end of a scan
	assign out_load = (q_pop && ((q_entry.op == OP_LIST) ||
			((q_entry.op == OP_TOKEN) && (halted_q || (q_entry.pre != STAT_OK))))) ||
		((state_q == S_DONE) && out_free);

	always_comb begin
		if (halted_q) begin
			list_st = STAT_HALTED;
		end else if (q_entry.started) begin
			list_st = STAT_MALFORMED;
		end else if (cnt_q == '0) begin
			list_st = STAT_EMPTY;
		end else begin
			list_st = STAT_OK;
		end
	end

	// value table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[cnt_q[ADDR_W-1:0]] <= cur_q;
		end
		if (mem_re) begin
			rdata_s1 <= table_mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			halted_q    <= 1'b0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_entry.op)
							OP_CLEAR: begin
								cnt_q    <= '0;
								halted_q <= 1'b0;
							end
							OP_LIST: begin
								if (!halted_q) begin
									if (list_st == STAT_OK) begin
										cnt_q <= '0;
									end else begin
										halted_q <= 1'b1;
									end
								end
							end
							OP_TOKEN: begin
								if (!halted_q) begin
									if (q_entry.pre != STAT_OK) begin
										halted_q <= 1'b1;
									end else begin
										idx_q   <= '0;
										pend_s1 <= 1'b0;
										state_q <= S_SCAN;
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					pend_s1 <= mem_re;
					if (mem_re) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (match) begin
						state_q <= S_DONE;
					end else if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (res_st_q == STAT_OK) begin
							cnt_q <= cnt_inc;
						end else begin
							halted_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan verdict and result payload
	always_ff @(posedge clk) begin
		if (q_pop && (q_entry.op == OP_TOKEN)) begin
			cur_q <= q_entry.value;
		end
		if (state_q == S_SCAN) begin
			if (match) begin
				res_st_q <= STAT_DUP;
			end else if (cnt_q >= CNT_W'(MAX_ITEMS)) begin
				res_st_q <= STAT_FULL;
			end else begin
				res_st_q <= STAT_OK;
			end
		end
		if (q_pop) begin
			value_q    <= '0;
			count_q    <= COUNT_W'(cnt_q);
			list_end_q <= (q_entry.op == OP_LIST);
			if (q_entry.op == OP_LIST) begin
				status_q <= list_st;
			end else if (halted_q) begin
				status_q <= STAT_HALTED;
			end else begin
				status_q <= q_entry.pre;
			end
		end else if ((state_q == S_DONE) && out_free) begin
			status_q   <= res_st_q;
			list_end_q <= 1'b0;
			if (res_st_q == STAT_OK) begin
				value_q <= cur_q;
				count_q <= COUNT_W'(cnt_inc);
			end else begin
				value_q <= '0;
				count_q <= COUNT_W'(cnt_q);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign count     = count_q;
	assign list_end  = list_end_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("entry count beyond table depth");
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cnt_q < CNT_W'(MAX_ITEMS)))
		else $error("store into full table");
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= cnt_q))
		else $error("scan index past entry count");
`endif

endmodule

`default_nettype wire

>>> rtl/decimal_int_list_validator_top.sv
// top level of the strict decimal list validator
`default_nettype none

// token characters: one beat per cycle, no result; stalled only while the queue is full
// end of token: queued; a well-formed token in range, while not halted, makes the back scan
//   the n stored values one per cycle, stopping at a match, before its result; other tokens answer at once
// end of list and clear: taken by the back in its idle state; a queue of four commands sits between
// reset: arst_n clears list count, halt flag, token state, queue and handshakes;
//   table contents stay undefined, no clearing pass is needed
module decimal_int_list_validator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      value,
	output logic [9:0]       count,
	output logic             list_end
);
	import dilv_pkg::*;

	// front to queue
	logic     push;
	q_entry_t push_entry;
	logic     full;

	// queue to back
	logic     pop;
	logic     pop_valid;
	q_entry_t pop_entry;

	// front: sign and digit checks, magnitude accumulation with overflow clamp,
	// and a precomputed status for each end of token
	dilv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.ch       (ch),
		.q_push   (push),
		.q_entry  (push_entry),
		.q_full   (full)
	);

	// commands wait here while the back is busy scanning or its output beat is not yet taken
	dilv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	// back: halt flag, entry count, duplicate scan over the table and the
	// output register that holds a beat until the sink takes it
	dilv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_entry   (pop_entry),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value     (value),
		.count     (count),
		.list_end  (list_end)
	);

endmodule

`default_nettype wire
